[design/wildcard_star_regex_matcher_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard/star pattern matcher
// Shared shorthand for concurrent checks clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_STAR_REGEX_MATCHER_UNIT_DEFINES_SVH
`define WILDCARD_STAR_REGEX_MATCHER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define WSRM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define WSRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/wsrm_pkg.sv]
// ----------------------------------------------------------------------------
// wsrm_pkg
// Types and constants shared by the matcher control, cells and checker.
// ----------------------------------------------------------------------------
package wsrm_pkg;

    // special pattern bytes
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    // width of the result payload packed in tdata (matched, pattern_dropped)
    localparam int RES_W  = 2;
    localparam int OUT_DW = 8;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // broadcast from control to every cell
    typedef struct packed {
        logic       restart;   // reload current row from empty-text row
        logic       wr;        // pattern append this cycle
        logic       emp_val;   // empty-text bit for the appended column
        logic [7:0] chr;       // byte being appended or text byte in flight
    } ctl_t;

    // wavefront record handed from one cell to the next
    typedef struct packed {
        logic tok;         // wavefront present
        logic old_m;       // previous-row match bit of the sending column
        logic new_m;       // new-row match bit of the sending column
        logic new_m_prev;  // new-row match bit one column further left
        logic old_d;       // previous exact-prefix bit of the sending column
        logic fin;         // new match bit of the last pattern column
    } hand_t;

endpackage

[design/wsrm_cell.sv]
// ----------------------------------------------------------------------------
// wsrm_cell
// One pattern column: holds its pattern byte, empty-text bit, current match
// bit and exact-prefix bit, and forwards the text wavefront to its neighbor.
// ----------------------------------------------------------------------------
module wsrm_cell #(
    parameter int INDEX = 1,
    parameter int LW    = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wsrm_pkg::ctl_t     ctl,
    input  logic [LW-1:0]      len,
    input  wsrm_pkg::hand_t    left,
    input  logic [7:0]         left_pat,
    output wsrm_pkg::hand_t    right,
    output logic [7:0]         pat
);

    logic [7:0]      pat_reg;
    logic            emp_reg;
    logic            cur_reg;
    logic            d_reg;
    wsrm_pkg::hand_t hand_reg;
    wsrm_pkg::hand_t hand_next;

    logic fit_self;
    logic fit_left;
    logic is_star;
    logic is_last;
    logic wr_hit;
    logic nm;
    logic nd;

    // byte tests against the text byte in flight
    assign fit_self = (pat_reg == ctl.chr) || (pat_reg == wsrm_pkg::DOT_BYTE);
    assign fit_left = (left_pat == ctl.chr) || (left_pat == wsrm_pkg::DOT_BYTE);
    assign is_star  = (pat_reg == wsrm_pkg::STAR_BYTE);
    assign is_last  = (len == LW'(INDEX));
    assign wr_hit   = ctl.wr && (len == LW'(INDEX - 1));

    // new match bit; a star with nothing before it never matches
    always_comb
    begin
        if (!is_star)
        begin
            nm = fit_self & left.old_m;
        end
        else if (INDEX >= 2)
        begin
            nm = left.new_m_prev | (fit_left & cur_reg);
        end
        else
        begin
            nm = 1'b0;
        end
    end

    // exact byte-for-byte prefix tracking
    assign nd = left.old_d & (pat_reg == ctl.chr);

    // record for the right neighbor
    always_comb
    begin
        hand_next.tok        = left.tok;
        hand_next.old_m      = cur_reg;
        hand_next.new_m      = nm;
        hand_next.new_m_prev = left.new_m;
        hand_next.old_d      = d_reg;
        hand_next.fin        = is_last ? (nm | nd) : left.fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_reg <= '0;
        end
        else
        begin
            hand_reg <= hand_next;
        end
    end

    // column storage; restart has priority over a passing wavefront
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            pat_reg <= ctl.chr;
            emp_reg <= ctl.emp_val;
        end
        if (ctl.restart)
        begin
            cur_reg <= wr_hit ? ctl.emp_val : emp_reg;
            d_reg   <= 1'b0;
        end
        else if (left.tok)
        begin
            cur_reg <= nm;
            d_reg   <= nd;
        end
    end

    assign right = hand_reg;
    assign pat   = pat_reg;

endmodule

[design/wsrm_ctrl.sv]
// ----------------------------------------------------------------------------
// wsrm_ctrl
// Stream handshake, pattern length, column zero, wavefront launch and the
// two-entry result queue.
// ----------------------------------------------------------------------------
module wsrm_ctrl #(
    parameter int N  = 64,
    parameter int LW = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wsrm_pkg::OUT_DW-1:0]   m_axis_tdata,
    output wsrm_pkg::ctl_t                ctl,
    output logic [LW-1:0]                 len,
    output wsrm_pkg::hand_t               launch,
    input  wsrm_pkg::hand_t               chain_exit
);

    localparam int RW = wsrm_pkg::RES_W;

    logic [LW-1:0]   len_reg,   len_next;
    logic            ovf_reg,   ovf_next;
    logic            l1_reg,    l1_next;    // empty-text bit of column len
    logic            l2_reg,    l2_next;    // empty-text bit of column len-1
    logic            cur0_reg,  cur0_next;
    logic            d0_reg,    d0_next;
    logic            fin_reg,   fin_next;   // match bit of the last column
    logic            busy_reg,  busy_next;
    logic [7:0]      byte_reg,  byte_next;
    wsrm_pkg::hand_t launch_reg, launch_next;
    logic            q0_v_reg,  q0_v_next;
    logic            q1_v_reg,  q1_v_next;
    logic [RW-1:0]   q0_d_reg,  q0_d_next;
    logic [RW-1:0]   q1_d_reg,  q1_d_next;

    wsrm_pkg::kind_t kind;
    logic            acc;
    logic            push;
    logic            pop;
    logic            restart;
    logic            wr;
    logic            new_e;
    logic [RW-1:0]   res;

    assign kind          = wsrm_pkg::kind_t'(s_axis_tuser);
    assign s_axis_tready = !busy_reg && !q1_v_reg;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign pop           = q0_v_reg && m_axis_tready;

    // empty-text bit of an appended column: a star repeats two columns back
    assign new_e = (s_axis_tdata == wsrm_pkg::STAR_BYTE) && (len_reg != '0) && l2_reg;
    assign res   = {ovf_reg, fin_reg};

    // item decode
    always_comb
    begin
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        l1_next     = l1_reg;
        l2_next     = l2_reg;
        cur0_next   = cur0_reg;
        d0_next     = d0_reg;
        fin_next    = fin_reg;
        busy_next   = busy_reg;
        byte_next   = byte_reg;
        launch_next = '0;
        push        = 1'b0;
        restart     = 1'b0;
        wr          = 1'b0;

        if (acc)
        begin
            unique case (kind)
                wsrm_pkg::KIND_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    l1_next  = 1'b1;
                    l2_next  = 1'b0;
                    restart  = 1'b1;
                end
                wsrm_pkg::KIND_APPEND:
                begin
                    if (len_reg == LW'(N))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr       = 1'b1;
                        len_next = len_reg + LW'(1);
                        l2_next  = l1_reg;
                        l1_next  = new_e;
                    end
                    byte_next = s_axis_tdata;
                    restart   = 1'b1;
                end
                wsrm_pkg::KIND_TEXT:
                begin
                    busy_next              = 1'b1;
                    byte_next              = s_axis_tdata;
                    launch_next.tok        = 1'b1;
                    launch_next.old_m      = cur0_reg;
                    launch_next.old_d      = d0_reg;
                    cur0_next              = 1'b0;
                    d0_next                = 1'b0;
                end
                wsrm_pkg::KIND_END:
                begin
                    push    = 1'b1;
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        // text restart: column zero matches the empty text
        if (restart)
        begin
            cur0_next = 1'b1;
            d0_next   = 1'b1;
            fin_next  = l1_next;
        end

        // wavefront has crossed the row
        if (chain_exit.tok)
        begin
            busy_next = 1'b0;
            fin_next  = chain_exit.fin;
        end
    end

    // result queue: head drives the port, second entry takes a result
    // while the head waits
    always_comb
    begin
        q0_v_next = q0_v_reg;
        q1_v_next = q1_v_reg;
        q0_d_next = q0_d_reg;
        q1_d_next = q1_d_reg;
        if (pop)
        begin
            q0_v_next = q1_v_reg;
            q0_d_next = q1_d_reg;
            q1_v_next = 1'b0;
        end
        if (push)
        begin
            if (!q0_v_next)
            begin
                q0_v_next = 1'b1;
                q0_d_next = res;
            end
            else
            begin
                q1_v_next = 1'b1;
                q1_d_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            l1_reg     <= 1'b1;
            l2_reg     <= 1'b0;
            cur0_reg   <= 1'b1;
            d0_reg     <= 1'b1;
            fin_reg    <= 1'b1;
            busy_reg   <= 1'b0;
            launch_reg <= '0;
            q0_v_reg   <= 1'b0;
            q1_v_reg   <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            l1_reg     <= l1_next;
            l2_reg     <= l2_next;
            cur0_reg   <= cur0_next;
            d0_reg     <= d0_next;
            fin_reg    <= fin_next;
            busy_reg   <= busy_next;
            launch_reg <= launch_next;
            q0_v_reg   <= q0_v_next;
            q1_v_reg   <= q1_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        q0_d_reg <= q0_d_next;
        q1_d_reg <= q1_d_next;
    end

    // cell broadcast; the appended byte goes out in the same cycle
    always_comb
    begin
        ctl.restart = restart;
        ctl.wr      = wr;
        ctl.emp_val = new_e;
        ctl.chr     = wr ? s_axis_tdata : byte_reg;
    end

    assign len           = len_reg;
    assign launch        = launch_reg;
    assign m_axis_tvalid = q0_v_reg;
    assign m_axis_tdata  = {(wsrm_pkg::OUT_DW - RW)'(0), q0_d_reg};

endmodule

[design/wildcard_star_regex_matcher_unit.sv]
// ----------------------------------------------------------------------------
// wildcard_star_regex_matcher_unit
// Whole-text matcher for patterns with '.' (any byte) and 'x*' (zero or
// more of x), built as a row of pattern-column cells.
// ----------------------------------------------------------------------------
// Pattern bytes are appended one per transfer into a row of PATTERN_MAX
// cells; each text byte then launches a wavefront that walks the row one
// cell per cycle, updating every column's match bit from its left neighbors.
// Clear, append and end-of-text transfers do not hold the input busy. A text
// byte is first registered for launch, then passes the register of each cell
// of the row in turn; tready is released once the wavefront leaves the last
// cell and stays low meanwhile.
// End of text queues one result (up to two may wait) and restarts the text.
// A text that equals the pattern byte for byte always matches. Pattern
// bytes beyond PATTERN_MAX are dropped and flagged until the next clear.
module wildcard_star_regex_matcher_unit #(
    parameter int PATTERN_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_dropped, [7:2] zero
);

    localparam int LW = $clog2(PATTERN_MAX + 1);

    wsrm_pkg::ctl_t  ctl;
    logic [LW-1:0]   len;
    wsrm_pkg::hand_t hand_w [0:PATTERN_MAX];
    logic [7:0]      pat_w  [0:PATTERN_MAX-1];

    // control, launch and result queue
    wsrm_ctrl #(
        .N  (PATTERN_MAX),
        .LW (LW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .ctl           (ctl),
        .len           (len),
        .launch        (hand_w[0]),
        .chain_exit    (hand_w[PATTERN_MAX])
    );

    // column zero has no pattern byte
    assign pat_w[0] = 8'h00;

    // cell row, column 1 at the left
    for (genvar i = 1; i <= PATTERN_MAX; i++)
    begin : g_cell
        if (i < PATTERN_MAX)
        begin : g_mid
            wsrm_cell #(
                .INDEX (i),
                .LW    (LW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .len      (len),
                .left     (hand_w[i-1]),
                .left_pat (pat_w[i-1]),
                .right    (hand_w[i]),
                .pat      (pat_w[i])
            );
        end
        else
        begin : g_end
            wsrm_cell #(
                .INDEX (i),
                .LW    (LW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .len      (len),
                .left     (hand_w[i-1]),
                .left_pat (pat_w[i-1]),
                .right    (hand_w[i]),
                .pat      ()
            );
        end
    end

endmodule

[design/wsrm_checker.sv]
// ----------------------------------------------------------------------------
// wsrm_checker
// Port-level checks on the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "wildcard_star_regex_matcher_unit_defines.svh"

module wsrm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic in_xfer;
    logic text_xfer;
    logic end_xfer;
    logic out_stall;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign text_xfer = in_xfer && (s_axis_tuser == wsrm_pkg::KIND_TEXT);
    assign end_xfer  = in_xfer && (s_axis_tuser == wsrm_pkg::KIND_END);
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a stalled result holds
    `WSRM_ASSERT_NEXT(a_hold, out_stall, $stable({m_axis_tvalid, m_axis_tdata}), "result moved")

    // a text byte keeps the input closed while its wavefront runs
    `WSRM_ASSERT_NEXT(a_text_busy, text_xfer, !s_axis_tready, "input open during wavefront")

    // a result only appears after an end-of-text transfer
    `WSRM_ASSERT_SAME(a_out_cause, $rose(m_axis_tvalid), $past(end_xfer), "result without end")

    // unused result bits stay zero
    `WSRM_ASSERT_SAME(a_out_pad, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0, "padding not zero")

endmodule

bind wildcard_star_regex_matcher_unit wsrm_checker u_wsrm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
